/* sv/tcw_pkg.sv */
// Shared codes, constants and interface types of the text console writer.
`default_nettype none

package tcw_pkg;

   // Field widths at the ports
   localparam int ROW_W = 5;
   localparam int COL_W = 7;
   localparam int POS_W = 11;

   // Transaction commands
   localparam logic [1:0] CMD_PUT  = 2'd0;
   localparam logic [1:0] CMD_SET  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // Interpreted control characters
   localparam logic [7:0] CH_BEL = 8'd7;
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_HT  = 8'd9;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_VT  = 8'd11;
   localparam logic [7:0] CH_FF  = 8'd12;
   localparam logic [7:0] CH_CR  = 8'd13;

   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   // Space with light gray on black: reset and scroll fill value
   localparam logic [15:0] BLANK_CELL = 16'h0720;

   // Command handed from the front end to the sequencer (row and col clamped)
   typedef struct packed {
      logic [1:0]       cmd;
      logic [7:0]       ch;
      logic [7:0]       attr;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } cmd_type;

   // Status returned by the sequencer
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [POS_W-1:0] pos;
      logic [15:0]      cell_word;
   } stat_type;

endpackage

`default_nettype wire

/* sv/tcw_cell_ram.sv */
// Screen cell memory: one write port, one read port with registered data.
`default_nettype none

module tcw_cell_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [15:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [15:0]       rd_data
);

   logic [15:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/tcw_ctrl.sv */
// Sequencer: cursor state and every read and write of the cell memory.
`default_nettype none

module tcw_ctrl
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    go,
   input  wire cmd_type cmd_i,
   output stat_type     stat_o
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);

   localparam logic [AW-1:0] ADDR_LAST   = AW'(CELLS - 1);
   localparam logic [AW-1:0] ADDR_SECOND = AW'(COLUMNS);
   localparam logic [AW-1:0] ADDR_BOTTOM = AW'((ROWS - 1) * COLUMNS);
   localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
   localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_FILL   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_BLANK  = 3'd5;
   localparam logic [2:0] S_READ   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] mv_addr_ff, mv_addr_in;
   logic          mv_pend_ff, mv_pend_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_data;

   logic [AW-1:0] cur_addr;
   logic [AW-1:0] req_addr;
   logic [15:0]   fill_word;

   tcw_cell_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Linear cell addresses of the cursor and of the requested cell
   assign cur_addr  = AW'(32'(row_ff) * COLUMNS + 32'(col_ff));
   assign req_addr  = AW'(32'(cmd_i.row) * COLUMNS + 32'(cmd_i.col));
   assign fill_word = {cmd_i.attr, CHAR_SPACE};

   // Next state, cursor and memory access
   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      addr_in    = addr_ff;
      mv_addr_in = mv_addr_ff;
      mv_pend_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = cur_addr;
      wr_data    = BLANK_CELL;
      rd_en      = 1'b0;
      rd_addr    = addr_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep the whole screen to blanks after reset
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            if (addr_ff == ADDR_LAST) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (go) begin
               state_in = S_DONE;
               unique case (cmd_i.cmd)
                  CMD_PUT: begin
                     unique case (cmd_i.ch) inside
                        CH_BS: begin
                           // Step back, wrapping to the previous row, and blank that cell
                           if (col_ff != '0 || row_ff != '0) begin
                              wr_en   = 1'b1;
                              wr_addr = cur_addr - 1'b1;
                              wr_data = fill_word;
                              if (col_ff != '0) begin
                                 col_in = col_ff - 1'b1;
                              end else begin
                                 row_in = row_ff - 1'b1;
                                 col_in = COL_LAST;
                              end
                           end
                        end
                        CH_LF: begin
                           state_in = S_FILL;
                        end
                        CH_CR: begin
                           col_in = '0;
                        end
                        CH_BEL, CH_HT, CH_VT, CH_FF: begin
                           state_in = S_DONE;
                        end
                        default: begin
                           // Write the character and advance
                           wr_en   = 1'b1;
                           wr_data = {cmd_i.attr, cmd_i.ch};
                           if (col_ff == COL_LAST) begin
                              col_in = '0;
                              if (row_ff == ROW_LAST) begin
                                 addr_in  = ADDR_SECOND;
                                 state_in = S_SCROLL;
                              end else begin
                                 row_in = row_ff + 1'b1;
                              end
                           end else begin
                              col_in = col_ff + 1'b1;
                           end
                        end
                     endcase
                  end
                  CMD_SET: begin
                     row_in = RW'(cmd_i.row);
                     col_in = CW'(cmd_i.col);
                  end
                  CMD_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = req_addr;
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_FILL: begin
            // Blank the rest of the row, one cell a cycle, using the cursor as counter
            wr_en   = 1'b1;
            wr_data = fill_word;
            if (col_ff == COL_LAST) begin
               col_in = '0;
               if (row_ff == ROW_LAST) begin
                  addr_in  = ADDR_SECOND;
                  state_in = S_SCROLL;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_SCROLL: begin
            // Read one row ahead, write the previous read one row up
            rd_en      = 1'b1;
            rd_addr    = addr_ff;
            mv_pend_in = 1'b1;
            mv_addr_in = addr_ff - ADDR_SECOND;
            wr_en      = mv_pend_ff;
            wr_addr    = mv_addr_ff;
            wr_data    = rd_data;
            if (addr_ff == ADDR_LAST) begin
               state_in = S_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // Finish the last move
            wr_en    = 1'b1;
            wr_addr  = mv_addr_ff;
            wr_data  = rd_data;
            addr_in  = ADDR_BOTTOM;
            state_in = S_BLANK;
         end
         S_BLANK: begin
            // Blank the bottom row with the default attribute
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            if (addr_ff == ADDR_LAST) begin
               addr_in  = '0;
               state_in = S_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         row_ff     <= '0;
         col_ff     <= '0;
         addr_ff    <= '0;
         mv_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         addr_ff    <= addr_in;
         mv_pend_ff <= mv_pend_in;
      end
   end

   // Move address needs no reset
   always_ff @(posedge clock) begin
      mv_addr_ff <= mv_addr_in;
   end

   // Report status; cell data is valid only in the read cycle
   always_comb begin
      stat_o.busy      = (state_ff == S_CLEAR);
      stat_o.done      = (state_ff == S_DONE) || (state_ff == S_READ);
      stat_o.row       = ROW_W'(row_ff);
      stat_o.col       = COL_W'(col_ff);
      stat_o.pos       = POS_W'(32'(row_ff) * COLUMNS + 32'(col_ff));
      stat_o.cell_word = (state_ff == S_READ) ? rd_data : 16'h0000;
   end

endmodule

`default_nettype wire

/* sv/text_console_writer.sv */
// Top level of the text console writer: request capture, clamping and result register.
//
//   channel   ports                                          handshake
//   request   req_cmd req_ch req_bg req_fg req_row req_col   taken when start && !busy
//   result    rsp_row rsp_col rsp_cursor_pos rsp_cell_*      rsp_valid, one cycle, no stall
//
// Put (plain character, backspace, carriage return, ignored codes), set cursor
// and read cell pass go_ff, then the sequencer's done or read state, then
// rsp_valid_ff; busy drops with rsp_valid, so one transaction is open at a time.
// Newline first blanks the COLUMNS - column cells left in the row.
// A scroll walks the cell memory through its read port and write port:
// (ROWS-1)*COLUMNS moves, a drain step and COLUMNS bottom-row blanks.
// After reset busy stays high while the screen clears.
// Every transaction returns exactly one result; the receiver cannot stall it.
`default_nettype none

module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [1:0]       req_cmd,
   input  wire logic [7:0]       req_ch,
   input  wire logic [3:0]       req_bg,
   input  wire logic [3:0]       req_fg,
   input  wire logic [ROW_W-1:0] req_row,
   input  wire logic [COL_W-1:0] req_col,
   output logic                  rsp_valid,
   output logic [ROW_W-1:0]      rsp_row,
   output logic [COL_W-1:0]      rsp_col,
   output logic [POS_W-1:0]      rsp_cursor_pos,
   output logic [7:0]            rsp_cell_char,
   output logic [7:0]            rsp_cell_attr
);

   localparam int ROW_MAX = ROWS - 1;
   localparam int COL_MAX = COLUMNS - 1;

   logic     accept;
   cmd_type  cmd_ff, cmd_in;
   logic     go_ff;
   logic     pend_ff;
   logic     rsp_valid_ff;
   stat_type stat;

   logic [ROW_W-1:0] rsp_row_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic [15:0]      rsp_cell_ff;

   tcw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .go     (go_ff),
      .cmd_i  (cmd_ff),
      .stat_o (stat)
   );

   assign busy   = pend_ff || stat.busy;
   assign accept = start && !busy;

   // Clamp the position and pack the attribute
   always_comb begin
      cmd_in.cmd  = req_cmd;
      cmd_in.ch   = req_ch;
      cmd_in.attr = {req_bg, req_fg};
      cmd_in.row  = (32'(req_row) > ROW_MAX) ? ROW_W'(ROW_MAX) : req_row;
      cmd_in.col  = (32'(req_col) > COL_MAX) ? COL_W'(COL_MAX) : req_col;
   end

   // Hold the command for the whole transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   // Track the open transaction and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         go_ff        <= accept;
         rsp_valid_ff <= stat.done;
         if (accept) begin
            pend_ff <= 1'b1;
         end else if (stat.done) begin
            pend_ff <= 1'b0;
         end
      end
   end

   // Register the result
   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_row_ff  <= stat.row;
         rsp_col_ff  <= stat.col;
         rsp_pos_ff  <= stat.pos;
         rsp_cell_ff <= stat.cell_word;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_col        = rsp_col_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_char  = rsp_cell_ff[7:0];
   assign rsp_cell_attr  = rsp_cell_ff[15:8];

endmodule

`default_nettype wire

/* sv/tcw_checker.sv */
// Port-level checks of the text console writer and their binding.
`default_nettype none

module tcw_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire logic [ROW_W-1:0] rsp_row,
   input wire logic [COL_W-1:0] rsp_col,
   input wire logic [POS_W-1:0] rsp_cursor_pos
);

   // An accepted transaction closes the request side until its result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low right after an accepted transaction");

   // One result per transaction: never two strobes back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // A result only follows a cycle with a transaction in flight
   a_result_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an open transaction");

   // Linear position agrees with the reported row and column
   a_pos_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ROWS <= 32 && COLUMNS <= 128 |->
         32'(rsp_cursor_pos) == ((32'(rsp_row) * COLUMNS + 32'(rsp_col)) & 32'h7FF)
         && 32'(rsp_row) < ROWS && 32'(rsp_col) < COLUMNS)
      else $error("cursor position out of range or inconsistent");

endmodule

bind text_console_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_row        (rsp_row),
   .rsp_col        (rsp_col),
   .rsp_cursor_pos (rsp_cursor_pos)
);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench of the text console writer: predicts each result and compares it.
module tb_top
   import tcw_pkg::*;
();

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELLS       = ROWS * COLUMNS;
   localparam int ITEM_COUNT  = 1450;
   // Longest quiet stretch is the reset clear or one scroll
   localparam int STALL_LIMIT = 20000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      bit [ROW_W-1:0] row;
      bit [COL_W-1:0] col;
      bit [POS_W-1:0] pos;
      bit [7:0]       cell_char;
      bit [7:0]       cell_attr;
   } console_status_type;

   // Screen and cursor predictor with the queue of results still owed by the block
   class console_scoreboard_type;
      bit [15:0]          cells [CELLS];
      bit [ROW_W-1:0]     cur_row;
      bit [COL_W-1:0]     cur_col;
      console_status_type status_due [$];
      int                 errors;

      function new();
         foreach (cells[i]) cells[i] = BLANK_CELL;
         cur_row = '0;
         cur_col = '0;
         errors  = 0;
      endfunction

      function int pending();
         return status_due.size();
      endfunction

      // Apply one accepted transaction to the screen and queue its status
      function void note_request(logic [1:0] cmd, logic [7:0] ch, logic [3:0] bg,
                                 logic [3:0] fg, logic [ROW_W-1:0] row,
                                 logic [COL_W-1:0] col);
         bit [ROW_W-1:0]     r;
         bit [COL_W-1:0]     c;
         bit [15:0]          blank;
         console_status_type st;
         int                 base;
         r = (row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : row;
         c = (col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : col;
         blank = {bg, fg, CHAR_SPACE};
         st.cell_char = '0;
         st.cell_attr = '0;
         case (cmd)
            CMD_PUT: begin
               base = cur_row * COLUMNS;
               case (ch)
                  CH_BS: begin
                     // Step back, wrapping to the previous row; nothing at home
                     if (cur_col != 0) begin
                        cur_col = cur_col - 1'b1;
                        cells[base + cur_col] = blank;
                     end else if (cur_row != 0) begin
                        cur_row = cur_row - 1'b1;
                        cur_col = COL_W'(COLUMNS - 1);
                        cells[cur_row * COLUMNS + cur_col] = blank;
                     end
                  end
                  CH_LF: begin
                     // Blank the rest of the row, then move to the next one
                     for (int k = int'(cur_col); k < COLUMNS; k++) cells[base + k] = blank;
                     cur_col = '0;
                     cur_row = cur_row + 1'b1;
                  end
                  CH_CR: cur_col = '0;
                  CH_BEL, CH_HT, CH_VT, CH_FF: ;
                  default: begin
                     cells[base + cur_col] = {bg, fg, ch};
                     cur_col = cur_col + 1'b1;
                  end
               endcase
               if (cur_col >= COLUMNS) begin
                  cur_col = '0;
                  cur_row = cur_row + 1'b1;
               end
               // Scroll up one row and blank the bottom row
               if (cur_row >= ROWS) begin
                  for (int k = 0; k < CELLS - COLUMNS; k++) cells[k] = cells[k + COLUMNS];
                  for (int k = CELLS - COLUMNS; k < CELLS; k++) cells[k] = BLANK_CELL;
                  cur_row = ROW_W'(ROWS - 1);
               end
            end
            CMD_SET: begin
               cur_row = r;
               cur_col = c;
            end
            CMD_READ: begin
               st.cell_char = cells[r * COLUMNS + c][7:0];
               st.cell_attr = cells[r * COLUMNS + c][15:8];
            end
            default: ;
         endcase
         st.row = cur_row;
         st.col = cur_col;
         st.pos = POS_W'(cur_row * COLUMNS + cur_col);
         status_due.push_back(st);
      endfunction

      // Compare one result with the oldest queued status
      function void check_result(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                 logic [POS_W-1:0] pos, logic [7:0] cell_char,
                                 logic [7:0] cell_attr);
         console_status_type st;
         if (status_due.size() == 0) begin
            $error("result with no transaction outstanding");
            errors++;
            return;
         end
         st = status_due.pop_front();
         if (row !== st.row) begin
            $error("cursor_row: expected %0d, actual %0d", st.row, row);
            errors++;
         end
         if (col !== st.col) begin
            $error("cursor_col: expected %0d, actual %0d", st.col, col);
            errors++;
         end
         if (pos !== st.pos) begin
            $error("cursor_pos: expected %0d, actual %0d", st.pos, pos);
            errors++;
         end
         if (cell_char !== st.cell_char) begin
            $error("cell_char: expected 0x%02h, actual 0x%02h", st.cell_char, cell_char);
            errors++;
         end
         if (cell_attr !== st.cell_attr) begin
            $error("cell_attr: expected 0x%02h, actual 0x%02h", st.cell_attr, cell_attr);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset   = 1'b1;
   logic             start   = 1'b0;
   logic             busy;
   logic [1:0]       req_cmd = '0;
   logic [7:0]       req_ch  = '0;
   logic [3:0]       req_bg  = '0;
   logic [3:0]       req_fg  = '0;
   logic [ROW_W-1:0] req_row = '0;
   logic [COL_W-1:0] req_col = '0;
   logic             rsp_valid;
   logic [ROW_W-1:0] rsp_row;
   logic [COL_W-1:0] rsp_col;
   logic [POS_W-1:0] rsp_cursor_pos;
   logic [7:0]       rsp_cell_char;
   logic [7:0]       rsp_cell_attr;

   console_scoreboard_type sb;
   bit                     idle_on = 1'b1;
   int                     items_sent = 0;
   int unsigned            quiet_cycles = 0;

   text_console_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_ch        (req_ch),
      .req_bg        (req_bg),
      .req_fg        (req_fg),
      .req_row       (req_row),
      .req_col       (req_col),
      .rsp_valid     (rsp_valid),
      .rsp_row       (rsp_row),
      .rsp_col       (rsp_col),
      .rsp_cursor_pos(rsp_cursor_pos),
      .rsp_cell_char (rsp_cell_char),
      .rsp_cell_attr (rsp_cell_attr)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Record accepted transactions and check strobed results
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result(rsp_row, rsp_col, rsp_cursor_pos,
                            rsp_cell_char, rsp_cell_attr);
         if (start && !busy)
            sb.note_request(req_cmd, req_ch, req_bg, req_fg, req_row, req_col);
      end
   end

   // End the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("text_console_writer regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one transaction, with an optional random gap, and hold it until taken
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                            input logic [3:0] bg, input logic [3:0] fg,
                            input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
      while (idle_on && $urandom_range(0, 99) < 37) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start   <= 1'b1;
      req_cmd <= cmd;
      req_ch  <= ch;
      req_bg  <= bg;
      req_fg  <= fg;
      req_row <= row;
      req_col <= col;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // Hold the sender off until every queued status has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mostly printable text, some control codes, some arbitrary bytes
   function automatic bit [7:0] pick_char();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) return 8'($urandom_range(8'h20, 8'h7e));
      else if (sel < 75) return 8'($urandom_range(CH_BEL, CH_CR));
      else return 8'($urandom);
   endfunction

   initial begin
      int             mode;
      bit             drained_mid;
      bit [ROW_W-1:0] r;
      bit [COL_W-1:0] c;
      drained_mid = 1'b0;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset contents, clamps, field extremes and every control case
      send_item(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
      send_item(CMD_READ, 8'hff, 4'hf, 4'hf, 5'd31, 7'd127);
      send_item(CMD_PUT, 8'h41, 4'hf, 4'hf, 5'd0, 7'd0);
      send_item(CMD_PUT, 8'hff, 4'h0, 4'h0, 5'd31, 7'd127);
      send_item(CMD_PUT, 8'h00, 4'ha, 4'h5, 5'd0, 7'd0);
      send_item(CMD_PUT, CH_BS, 4'h1, 4'he, 5'd0, 7'd0);
      send_item(CMD_SET, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
      send_item(CMD_PUT, CH_BS, 4'h2, 4'h3, 5'd0, 7'd0);
      send_item(CMD_SET, 8'h00, 4'h0, 4'h0, 5'd1, 7'd0);
      send_item(CMD_PUT, CH_BS, 4'h4, 4'h6, 5'd0, 7'd0);
      send_item(CMD_PUT, CH_CR, 4'h0, 4'h0, 5'd0, 7'd0);
      send_item(CMD_PUT, CH_BEL, 4'h0, 4'h0, 5'd0, 7'd0);
      send_item(CMD_PUT, CH_HT, 4'h0, 4'h0, 5'd0, 7'd0);
      send_item(CMD_PUT, CH_VT, 4'h0, 4'h0, 5'd0, 7'd0);
      send_item(CMD_PUT, CH_FF, 4'h0, 4'h0, 5'd0, 7'd0);
      send_item(CMD_SET, 8'h00, 4'h0, 4'h0, 5'd3, 7'd40);
      send_item(CMD_PUT, CH_LF, 4'hc, 4'h9, 5'd0, 7'd0);
      send_item(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd3, 7'd79);
      send_item(CMD_SET, 8'h00, 4'h0, 4'h0, 5'd31, 7'd127);
      send_item(CMD_PUT, 8'h5a, 4'h7, 4'h1, 5'd0, 7'd0);
      send_item(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd23, 7'd79);
      send_item(CMD_SET, 8'h00, 4'h0, 4'h0, 5'd24, 7'd10);
      send_item(CMD_PUT, CH_LF, 4'h3, 4'hb, 5'd0, 7'd0);
      send_item(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd24, 7'd0);
      send_item(CMD_UNUSED, 8'($urandom), 4'($urandom), 4'($urandom), 5'($urandom),
                7'($urandom));
      drain_results();

      // Random: text bursts at random places, scattered reads and raw noise
      while (items_sent < ITEM_COUNT) begin
         idle_on = !(items_sent >= 500 && items_sent < 750);
         if (!drained_mid && items_sent >= 900) begin
            drain_results();
            drained_mid = 1'b1;
         end
         mode = $urandom_range(0, 99);
         if (mode < 65) begin
            r = ($urandom_range(0, 99) < 15) ? 5'($urandom_range(24, 31))
                                              : 5'($urandom_range(0, 23));
            c = ($urandom_range(0, 99) < 25) ? 7'($urandom_range(70, 127))
                                              : 7'($urandom_range(0, 79));
            send_item(CMD_SET, 8'($urandom), 4'($urandom), 4'($urandom), r, c);
            repeat ($urandom_range(1, 8))
               send_item(CMD_PUT, pick_char(), 4'($urandom), 4'($urandom), 5'($urandom),
                         7'($urandom));
            repeat ($urandom_range(0, 2))
               send_item(CMD_READ, 8'($urandom), 4'($urandom), 4'($urandom), sb.cur_row,
                         7'($urandom_range(0, 79)));
         end else if (mode < 85) begin
            send_item(CMD_READ, 8'($urandom), 4'($urandom), 4'($urandom), 5'($urandom),
                      7'($urandom));
         end else begin
            send_item(2'($urandom), 8'($urandom), 4'($urandom), 4'($urandom), 5'($urandom),
                      7'($urandom));
         end
      end

      // Wait out every outstanding result, then a short tail
      drain_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("text_console_writer regression: pass");
      else
         $display("text_console_writer regression: fail");
      $finish;
   end

endmodule
